FILE: hw/rtl/pmd_pkg.sv
// pmd_pkg: shared types, constants and the letter lookup for the packed Morse decoder.
// Used by pmd_ctrl, pmd_dp, packed_morse_decoder and pmd_checker. No dependencies.
package pmd_pkg;

    localparam int SYMBOLS_PER_WORD_DEF = 32;
    localparam int SYM_W                = 2;
    localparam int WORD_W               = 64;
    localparam int LETTER_W             = 8;
    localparam int PAT_W                = 4;
    localparam int LEN_W                = 3;
    localparam int MAX_PENDING          = 5;
    localparam int MAX_CODE_LEN         = 4;

    // symbol codes
    localparam logic [SYM_W-1:0] SYM_DOT  = 2'd0;
    localparam logic [SYM_W-1:0] SYM_DASH = 2'd1;
    localparam logic [SYM_W-1:0] SYM_GAP  = 2'd2;
    localparam logic [SYM_W-1:0] SYM_END  = 2'd3;

    localparam logic [LETTER_W-1:0] CHAR_UNKNOWN = 8'h3F;

    // indexed by (1 << length) | pattern, lengths 1..4
    localparam logic [LETTER_W-1:0] LETTER_TABLE [32] = '{
        "?", "?",
        "E", "T",
        "I", "A", "N", "M",
        "S", "U", "R", "W", "D", "K", "G", "O",
        "H", "V", "F", "?", "L", "?", "P", "J",
        "B", "X", "C", "Y", "Z", "Q", "?", "?"
    };

    // controller -> datapath
    typedef struct packed {
        logic load;      // take a new word
        logic step;      // consume the current symbol
        logic emit_eow;  // move held letter to output as last of word
    } pmd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic close;       // current symbol is gap or end
        logic is_end;      // current symbol is end
        logic last;        // current symbol is the lowest pair
        logic held_valid;  // a letter waits for its successor
        logic out_free;    // output register can take a letter
    } pmd_status_t;

    function automatic logic [LETTER_W-1:0] lookup_letter(
        input logic [PAT_W-1:0] pattern,
        input logic [LEN_W-1:0] len
    );
        logic [4:0] idx;
        idx = 5'((5'd1 << len) | {1'b0, pattern});
        if (len == '0 || len >= LEN_W'(MAX_PENDING)) begin
            return CHAR_UNKNOWN;
        end
        return LETTER_TABLE[idx];
    endfunction

endpackage

FILE: hw/rtl/pmd_ctrl.sv
// pmd_ctrl: sequencer for the packed Morse decoder (idle, scan, flush).
// Depends on pmd_pkg for the command and status structs.
module pmd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pmd_pkg::pmd_status_t st,
    output pmd_pkg::pmd_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // stall only when a new letter would overrun held + output
                if (!(st.close && st.held_valid && !st.out_free)) begin
                    cmd.step = 1'b1;
                    if (st.is_end || st.last) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!st.held_valid) begin
                    state_next = ST_IDLE;
                end else if (st.out_free) begin
                    cmd.emit_eow = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

FILE: hw/rtl/pmd_dp.sv
// pmd_dp: datapath of the packed Morse decoder: symbol shifter, pending code,
// held letter and output register. Depends on pmd_pkg.
module pmd_dp #(
    parameter int SYMBOLS_PER_WORD = pmd_pkg::SYMBOLS_PER_WORD_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [pmd_pkg::WORD_W-1:0]     s_tdata,
    input  logic                           s_tlast,
    output logic [pmd_pkg::LETTER_W-1:0]   m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  pmd_pkg::pmd_cmd_t              cmd,
    output pmd_pkg::pmd_status_t           st
);

    localparam int BitsW = 2 * SYMBOLS_PER_WORD;
    localparam int CntW  = (SYMBOLS_PER_WORD > 1) ? $clog2(SYMBOLS_PER_WORD) : 1;

    logic [BitsW-1:0]                 word_reg, word_next;
    logic [CntW-1:0]                  pos_reg, pos_next;
    logic                             final_reg, final_next;
    logic [pmd_pkg::PAT_W-1:0]        pat_reg, pat_next;
    logic [pmd_pkg::LEN_W-1:0]        len_reg, len_next;
    logic                             held_valid_reg, held_valid_next;
    logic [pmd_pkg::LETTER_W-1:0]     held_letter_reg, held_letter_next;
    logic                             held_eom_reg, held_eom_next;
    logic                             out_valid_reg, out_valid_next;
    logic [pmd_pkg::LETTER_W-1:0]     out_letter_reg, out_letter_next;
    logic                             out_eom_reg, out_eom_next;
    logic                             out_eow_reg, out_eow_next;

    logic [pmd_pkg::SYM_W-1:0]        sym;
    logic                             push;
    logic                             push_eow;

    assign sym = word_reg[BitsW-1 -: pmd_pkg::SYM_W];

    assign st.close      = (sym == pmd_pkg::SYM_GAP) || (sym == pmd_pkg::SYM_END);
    assign st.is_end     = (sym == pmd_pkg::SYM_END);
    assign st.last       = (pos_reg == '0);
    assign st.held_valid = held_valid_reg;
    assign st.out_free   = !out_valid_reg || m_tready;

    always_comb begin
        word_next        = word_reg;
        pos_next         = pos_reg;
        final_next       = final_reg;
        pat_next         = pat_reg;
        len_next         = len_reg;
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        held_eom_next    = held_eom_reg;
        push             = 1'b0;
        push_eow         = 1'b0;

        if (cmd.load) begin
            word_next  = s_tdata[BitsW-1:0];
            pos_next   = CntW'(SYMBOLS_PER_WORD - 1);
            final_next = s_tlast;
        end

        if (cmd.step) begin
            word_next = word_reg << pmd_pkg::SYM_W;
            pos_next  = pos_reg - CntW'(1);
            if (st.close) begin
                // previous letter is not last of word: send it on
                if (held_valid_reg) begin
                    push = 1'b1;
                end
                held_valid_next  = 1'b1;
                held_letter_next = pmd_pkg::lookup_letter(pat_reg, len_reg);
                held_eom_next    = st.is_end;
                pat_next         = '0;
                len_next         = '0;
            end else if (len_reg < pmd_pkg::LEN_W'(pmd_pkg::MAX_CODE_LEN)) begin
                pat_next = {pat_reg[pmd_pkg::PAT_W-2:0], sym[0]};
                len_next = len_reg + pmd_pkg::LEN_W'(1);
            end else begin
                len_next = pmd_pkg::LEN_W'(pmd_pkg::MAX_PENDING);
            end
            // leftover code of a final word is dropped
            if (final_reg && (st.is_end || st.last)) begin
                pat_next = '0;
                len_next = '0;
            end
        end

        if (cmd.emit_eow) begin
            push            = 1'b1;
            push_eow        = 1'b1;
            held_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_letter_next = out_letter_reg;
        out_eom_next    = out_eom_reg;
        out_eow_next    = out_eow_reg;
        if (push) begin
            out_valid_next  = 1'b1;
            out_letter_next = held_letter_reg;
            out_eom_next    = held_eom_reg;
            out_eow_next    = push_eow;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg        <= '0;
            len_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pat_reg        <= pat_next;
            len_reg        <= len_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg        <= word_next;
        pos_reg         <= pos_next;
        final_reg       <= final_next;
        held_letter_reg <= held_letter_next;
        held_eom_reg    <= held_eom_next;
        out_letter_reg  <= out_letter_next;
        out_eom_reg     <= out_eom_next;
        out_eow_reg     <= out_eow_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_letter_reg;
    assign m_tuser  = out_eom_reg;
    assign m_tlast  = out_eow_reg;

endmodule

FILE: hw/rtl/packed_morse_decoder.sv
// packed_morse_decoder: top level, joins the pmd_ctrl sequencer and the pmd_dp datapath.
// Depends on pmd_pkg, pmd_ctrl and pmd_dp.

// A word arrives on the s_ stream as SYMBOLS_PER_WORD two-bit Morse symbols,
// read from the top pair down (dot, dash, letter gap, end of message); s_tlast
// marks the last word of a stream, after which any unfinished letter code is
// dropped. Each gap or end code yields one m_ transfer with the ASCII letter
// 'A'..'Z', or '?' for an empty, unknown or over-long code. m_tuser flags the
// letter closed by the end code (the rest of that word is skipped), and m_tlast
// marks the last letter a word produced; a word that closes no letter gives no
// transfer. Symbols are consumed one per clock by the scan sequencer unless the
// scan is paused; a word passes through a load step, the scan and a flush step,
// and an end code stops the scan early. The last letter of a word is held back
// until the scan finishes so it can carry m_tlast; a stalled m_ side pauses the
// scan when a gap or end code arrives while both the held letter and the output
// register are full. There are no configuration registers.
module packed_morse_decoder #(
    parameter int SYMBOLS_PER_WORD = pmd_pkg::SYMBOLS_PER_WORD_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pmd_pkg::WORD_W-1:0]   s_tdata,   // [63:0] symbol_word
    input  logic                         s_tlast,   // final_word
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pmd_pkg::LETTER_W-1:0] m_tdata,   // [7:0] letter
    output logic                         m_tuser,   // [0] end_of_message
    output logic                         m_tlast    // end_of_word
);

    pmd_pkg::pmd_cmd_t    cmd;
    pmd_pkg::pmd_status_t st;

    pmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pmd_dp #(
        .SYMBOLS_PER_WORD (SYMBOLS_PER_WORD)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

FILE: hw/rtl/pmd_checker.sv
// pmd_checker: port-level assertions for packed_morse_decoder, attached by bind.
// Depends on pmd_pkg for widths and the unknown-letter code only.
module pmd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pmd_pkg::LETTER_W-1:0] m_tdata,
    input logic                         m_tuser,
    input logic                         m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // end code stops the word, so its letter is the word's last
    a_eom_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end-of-message letter without end of word");

    a_letter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == pmd_pkg::CHAR_UNKNOWN)
            || ((m_tdata >= 8'h41) && (m_tdata <= 8'h5A)))
        else $error("letter outside A..Z and ?");

    // one word in flight at a time
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken during scan");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs active after reset");

endmodule

bind packed_morse_decoder pmd_checker u_pmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
